>>> rtl/tmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared widths, constants and types of the trimmed-mean pH filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int GROUP_SIZE_DEF    = 10;
  localparam int TRIM_EACH_END_DEF = 2;
  localparam int ADC_BITS_DEF      = 10;

  localparam int SAMPLE_W = 10;
  localparam int MSUM_W   = 13;
  localparam int PH_W     = 12;
  localparam int GAIN_W   = 12;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1750;
  localparam logic [MSUM_W-1:0] MSUM_MAX   = 13'd8191;
  localparam logic [PH_W-1:0]   PH_MAX     = 12'd4095;
  localparam int                PH_LIMIT   = 4096;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

endpackage

>>> rtl/tmf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_if
// Valid/ready channels of the trimmed-mean pH filter.
// ----------------------------------------------------------------------------
interface tmf_in_if;
  import tmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmf_out_if;
  import tmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [MSUM_W-1:0] middle_sum;
  logic [PH_W-1:0]   ph_centi;
  modport source (output valid, output middle_sum, output ph_centi, input ready);
  modport sink   (input valid, input middle_sum, input ph_centi, output ready);
endinterface

interface tmf_cfg_if;
  import tmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] ph_gain;
  modport source (output valid, output ph_gain, input ready);
  modport sink   (input valid, input ph_gain, output ready);
endinterface

>>> rtl/trimmed_mean_ph_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_ph_filter
// Sorts ADC samples in a cell chain, sums the middle of each group and
// scales the sum to pH in hundredths.
//
//   channel | dir | payload                    | transaction
//   in_ch   | in  | sample[9:0]                | valid && ready
//   out_ch  | out | middle_sum[12:0], ph_centi | valid && ready
//   cfg_ch  | in  | ph_gain[11:0]              | valid && ready
//
// Samples are taken one per cycle while in_ready is high. The sample that
// closes a group holds in_ready low until the result register is loaded:
// the chain drains into the accumulator, then multiply, clamp, reciprocal
// multiply and correction run. A full result register delays the load.
// Reset empties the group and loads ph_gain with 1750; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module trimmed_mean_ph_filter #(
  parameter int GROUP_SIZE    = tmf_pkg::GROUP_SIZE_DEF,
  parameter int TRIM_EACH_END = tmf_pkg::TRIM_EACH_END_DEF,
  parameter int ADC_BITS      = tmf_pkg::ADC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tmf_in_if.sink     in_ch,
  tmf_out_if.source  out_ch,
  tmf_cfg_if.sink    cfg_ch
);
  import tmf_pkg::*;

  localparam int HAS_MID   = (2 * TRIM_EACH_END < GROUP_SIZE) ? 1 : 0;
  localparam int MID       = (HAS_MID != 0) ? GROUP_SIZE - 2 * TRIM_EACH_END : 1;
  localparam int DRAIN_LEN = (HAS_MID != 0) ? GROUP_SIZE - TRIM_EACH_END : 1;
  localparam int CNT_W     = $clog2(GROUP_SIZE);
  localparam int DCNT_W    = $clog2(DRAIN_LEN + 1);
  localparam int SUM_W     = ADC_BITS + $clog2(MID + 1);
  localparam int PROD_W    = SUM_W + GAIN_W;
  localparam int TRAW_W    = PROD_W - ADC_BITS;
  localparam int T_W       = $clog2(PH_LIMIT * MID + 1);
  localparam int RECIP_W   = T_W + 1;
  localparam int QP_W      = T_W + RECIP_W;
  localparam int REM_W     = $clog2(2 * MID) + 1;

  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << T_W) / MID);
  localparam logic [T_W-1:0]     T_LIMIT = T_W'(PH_LIMIT * MID);

  typedef enum logic [2:0] {
    ST_FILL, ST_DRAIN, ST_MUL, ST_CLAMP, ST_RECIP, ST_CORR, ST_EMIT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic [SUM_W-1:0]    acc_r;
  logic [PROD_W-1:0]   prod_r;
  logic [T_W-1:0]      t_r;
  logic [QP_W-1:0]     qp_r;
  logic [T_W-1:0]      q0_r;
  logic [REM_W-1:0]    rem_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                out_valid_r;
  logic [MSUM_W-1:0]   msum_r;
  logic [PH_W-1:0]     ph_r;

  logic                in_acc;
  logic                grp_done;
  logic [ADC_BITS+SAMPLE_W-1:0] sample_ext;
  logic [ADC_BITS-1:0] smp;
  cell_ctrl_t          ctrl;
  logic [GROUP_SIZE-1:0] occ;
  logic [GROUP_SIZE-1:0] gt;
  logic [ADC_BITS-1:0] cval [GROUP_SIZE];

  logic [TRAW_W-1:0]   t_raw;
  logic [T_W-1:0]      q0_w;
  logic [T_W-1:0]      q0m_w;
  logic [T_W:0]        q_w;
  logic [SUM_W+MSUM_W-1:0] sum_ext;
  logic [MSUM_W-1:0]   msum_w;
  logic [PH_W-1:0]     ph_w;

  assign in_ch.ready = (state_r == ST_FILL);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign grp_done    = in_acc && (count_r == CNT_W'(GROUP_SIZE - 1));
  assign sample_ext  = {{ADC_BITS{1'b0}}, in_ch.sample};
  assign smp         = sample_ext[ADC_BITS-1:0];
  assign ctrl.ins    = in_acc;
  assign ctrl.drain  = (state_r == ST_DRAIN);

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.middle_sum = msum_r;
  assign out_ch.ph_centi   = ph_r;

  for (genvar gi = 0; gi < GROUP_SIZE; gi++) begin : g_cell
    assign occ[gi] = (32'(count_r) > 32'(gi));
    tmf_cell #(.W(ADC_BITS)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sample    (smp),
      .occ       (occ[gi]),
      .left_val  ((gi == 0) ? '0 : cval[(gi == 0) ? 0 : gi - 1]),
      .left_gt   ((gi == 0) ? 1'b0 : gt[(gi == 0) ? 0 : gi - 1]),
      .right_val ((gi == GROUP_SIZE - 1) ? '0 : cval[(gi == GROUP_SIZE - 1) ? gi : gi + 1]),
      .val       (cval[gi]),
      .gt        (gt[gi])
    );
  end

  always_comb begin
    t_raw   = prod_r[PROD_W-1:ADC_BITS];
    q0_w    = qp_r[2*T_W-1:T_W];
    q0m_w   = T_W'(q0_w * T_W'(MID));
    q_w     = (T_W + 1)'(q0_r) + (T_W + 1)'(rem_r >= REM_W'(MID));
    ph_w    = (q_w > (T_W + 1)'(PH_MAX)) ? PH_MAX : q_w[PH_W-1:0];
    sum_ext = (SUM_W + MSUM_W)'(acc_r);
    msum_w  = (sum_ext > (SUM_W + MSUM_W)'(MSUM_MAX)) ? MSUM_MAX : sum_ext[MSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      dcnt_r      <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        gain_r <= cfg_ch.ph_gain;
      end
      if (out_ch.valid && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_FILL: begin
          if (in_acc) begin
            count_r <= grp_done ? '0 : count_r + CNT_W'(1);
          end
          if (grp_done) begin
            dcnt_r  <= '0;
            acc_r   <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if ((HAS_MID != 0) && (32'(dcnt_r) >= 32'(TRIM_EACH_END))) begin
            acc_r <= acc_r + SUM_W'(cval[0]);
          end
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DRAIN_LEN - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(acc_r) * PROD_W'(gain_r);
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          t_r     <= (t_raw > TRAW_W'(T_LIMIT)) ? T_LIMIT : T_W'(t_raw);
          state_r <= ST_RECIP;
        end
        ST_RECIP: begin
          qp_r    <= QP_W'(t_r) * QP_W'(RECIP);
          state_r <= ST_CORR;
        end
        ST_CORR: begin
          q0_r    <= q0_w;
          rem_r   <= REM_W'(t_r - q0m_w);
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            msum_r      <= msum_w;
            ph_r        <= ph_w;
            out_valid_r <= 1'b1;
            state_r     <= ST_FILL;
          end
        end
        default: begin
          state_r <= ST_FILL;
        end
      endcase
    end
  end

endmodule

>>> rtl/tmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_cell
// One slot of the insertion-sort chain: inserts, shifts up, or drains down.
// ----------------------------------------------------------------------------
module tmf_cell #(
  parameter int W = tmf_pkg::ADC_BITS_DEF
) (
  input  logic               clk,
  input  tmf_pkg::cell_ctrl_t ctrl,
  input  logic [W-1:0]       sample,
  input  logic               occ,
  input  logic [W-1:0]       left_val,
  input  logic               left_gt,
  input  logic [W-1:0]       right_val,
  output logic [W-1:0]       val,
  output logic               gt
);
  import tmf_pkg::*;

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  assign gt  = occ && (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.drain) begin
      val_nxt = right_val;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (!occ || (val_r > sample)) begin
        val_nxt = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> rtl/tmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_checker
// Port-level checks of the trimmed-mean pH filter, bound to the top level.
// ----------------------------------------------------------------------------
module tmf_checker #(
  parameter int GROUP_SIZE = tmf_pkg::GROUP_SIZE_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tmf_pkg::MSUM_W-1:0] middle_sum,
  input logic [tmf_pkg::PH_W-1:0]   ph_centi
);
  import tmf_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SIZE);

  logic [CNT_W-1:0] grp_cnt_r;
  logic [1:0]       pend_r;
  logic             in_acc;
  logic             out_acc;
  logic             grp_end;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign grp_end = in_acc && (grp_cnt_r == CNT_W'(GROUP_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
      pend_r    <= '0;
    end else begin
      if (in_acc) begin
        grp_cnt_r <= grp_end ? '0 : grp_cnt_r + CNT_W'(1);
      end
      pend_r <= pend_r + 2'(grp_end) - 2'(out_acc);
    end
  end

  a_busy_after_group: assert property (@(posedge clk) disable iff (!rst_n)
    grp_end |=> !in_ready)
    else $error("input taken right after a group closed");

  a_result_has_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result without a completed group");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side was open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(middle_sum) && $stable(ph_centi)))
    else $error("stalled result changed");

endmodule

bind trimmed_mean_ph_filter tmf_checker #(.GROUP_SIZE(GROUP_SIZE)) u_tmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .middle_sum (out_ch.middle_sum),
  .ph_centi   (out_ch.ph_centi)
);
